FILE: rtl/sorted_priority_queue_assert.svh
// Assertion helpers for the checker of the priority queue.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
package spq_pkg;

   // Number of entries the queue can hold.
   localparam int CAPACITY = 16;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int OCC_W = 5;
   localparam int DATA_W = 32;

   // Operation codes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_PUSHED = 2'd0;
   localparam logic [1:0] ST_POPPED = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // Read address selection.
   localparam logic RD_HEAD = 1'b0;
   localparam logic RD_PREV = 1'b1;

   // Write data selection.
   localparam logic WR_NEW   = 1'b0;
   localparam logic WR_SHIFT = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic       accept;
      logic       rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       pos_dec;
      logic       count_inc;
      logic       pop_take;
      logic       load_rsp;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic stored_ge;
   } sts_type;

   // Physical slot of a logical position in the circular store.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] logical);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(logical);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/spq_if.sv
interface spq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic signed [spq_pkg::DATA_W-1:0]    item_value;
   logic signed [spq_pkg::DATA_W-1:0]    item_priority;

   modport source (output valid, output op, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input op, input item_value, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic signed [spq_pkg::DATA_W-1:0]    popped_value;
   logic signed [spq_pkg::DATA_W-1:0]    popped_priority;
   logic [spq_pkg::OCC_W-1:0]            occupancy;

   modport source (output valid, output status, output popped_value,
                   output popped_priority, output occupancy, input ready);
   modport sink   (input valid, input status, input popped_value,
                   input popped_priority, input occupancy, output ready);
endinterface

FILE: rtl/spq_datapath.sv
module spq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  spq_pkg::cmd_type                  cmd,
   output spq_pkg::sts_type                  sts,
   input  logic signed [spq_pkg::DATA_W-1:0] req_item_value,
   input  logic signed [spq_pkg::DATA_W-1:0] req_item_priority,
   output logic [1:0]                        rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_popped_value,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_popped_priority,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import spq_pkg::*;

   entry_type                mem [CAPACITY];
   entry_type                rd_data_ff;
   entry_type                new_ff;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic signed [DATA_W-1:0] pv_ff, pp_ff;
   logic [1:0]               status_ff;
   logic signed [DATA_W-1:0] out_pv_ff, out_pp_ff;
   logic [OCC_W-1:0]         occ_ff;
   logic [IDX_W-1:0]         rd_addr, wr_addr;
   entry_type                wr_data;

   assign rd_addr = (cmd.rd_sel == RD_PREV) ? slot_of(head_ff, pos_ff - CNT_W'(1))
                                             : head_ff;
   assign wr_addr = slot_of(head_ff, pos_ff);
   assign wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_data_ff : new_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (cmd.accept) begin
         pos_in = count_ff;
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - CNT_W'(1);
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop_take) begin
         count_in = count_ff - CNT_W'(1);
         head_in  = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.accept) begin
         new_ff.value <= req_item_value;
         new_ff.prio  <= req_item_priority;
         pv_ff        <= '0;
         pp_ff        <= '0;
      end else if (cmd.pop_take) begin
         pv_ff <= rd_data_ff.value;
         pp_ff <= rd_data_ff.prio;
      end
      if (cmd.load_rsp) begin
         status_ff <= cmd.status;
         out_pv_ff <= pv_ff;
         out_pp_ff <= pp_ff;
         occ_ff    <= OCC_W'(count_ff);
      end
   end

   assign sts.full      = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty     = (count_ff == '0);
   assign sts.pos_zero  = (pos_ff == '0);
   assign sts.stored_ge = !(rd_data_ff.prio < new_ff.prio);

   assign rsp_status          = status_ff;
   assign rsp_popped_value    = out_pv_ff;
   assign rsp_popped_priority = out_pp_ff;
   assign rsp_occupancy       = occ_ff;

endmodule

FILE: rtl/spq_controller.sv
module spq_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   input  spq_pkg::sts_type sts,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PUSH_RD  = 3'd1;
   localparam logic [2:0] S_PUSH_CMP = 3'd2;
   localparam logic [2:0] S_POP_TAKE = 3'd3;
   localparam logic [2:0] S_RESP     = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = RD_HEAD;
      cmd.wr_sel = WR_NEW;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_PUSH) begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     status_in = ST_PUSHED;
                     state_in  = S_PUSH_RD;
                  end
               end else begin
                  if (sts.empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     status_in = ST_POPPED;
                     state_in  = S_POP_TAKE;
                  end
               end
            end
         end
         S_PUSH_RD: begin
            if (sts.pos_zero) begin
               cmd.wr_en     = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.rd_sel = RD_PREV;
               state_in   = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.stored_ge) begin
               cmd.wr_sel  = WR_SHIFT;
               cmd.pos_dec = 1'b1;
               state_in    = S_PUSH_RD;
            end else begin
               cmd.count_inc = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_POP_TAKE: begin
            cmd.pop_take = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_PUSHED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/sorted_priority_queue.sv
// Bounded min-priority queue holding up to CAPACITY entries (a 32-bit data
// word and a 32-bit signed priority) in ascending priority order in a single
// memory with one read and one write port, used as a circular buffer. Each
// request beat is a push or a pop and yields exactly one response beat,
// carrying a status (pushed, popped, pop on empty, push on full dropped), the
// removed entry on a successful pop (zero otherwise) and the occupancy after
// the operation. A new entry goes in front of every held entry of equal or
// greater priority, so among equal priorities the newest is served first.
// One request is worked at a time. A pop passes through a take state and then
// the response state, and a rejected push or empty pop goes straight to the
// response state. A push walks from the tail of the list towards the head,
// moving one entry per step, where each step reads a slot through the
// registered memory port and then writes it one place on; it stops behind a
// smaller entry or lands at the head. In the response state the response is
// loaded into an output register; if the previous response is still waiting
// there, the block stays in that state until it leaves. A finished response
// waits in the output register, and the next request may be accepted while
// it does.

module sorted_priority_queue (
   input logic     clock,
   input logic     reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   // Commands from the controller and status back from the datapath.
   cmd_type cmd;
   sts_type sts;

   // The controller sequences each request and owns both handshakes.
   spq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the entry store, head pointer, count, and the
   // response payload register.
   spq_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_item_value      (req_ch.item_value),
      .req_item_priority   (req_ch.item_priority),
      .rsp_status          (rsp_ch.status),
      .rsp_popped_value    (rsp_ch.popped_value),
      .rsp_popped_priority (rsp_ch.popped_priority),
      .rsp_occupancy       (rsp_ch.occupancy)
   );

endmodule

FILE: rtl/spq_checker.sv
`include "sorted_priority_queue_assert.svh"

module spq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic signed [spq_pkg::DATA_W-1:0] rsp_popped_value,
   input logic signed [spq_pkg::DATA_W-1:0] rsp_popped_priority,
   input logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import spq_pkg::*;

   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy), "stalled response changed")
   `SPQ_ASSERT_NOW(a_occ_bound, rsp_valid, rsp_occupancy <= OCC_W'(CAPACITY), "occupancy beyond capacity")
   `SPQ_ASSERT_NOW(a_zero_fields, rsp_valid && (rsp_status != ST_POPPED), (rsp_popped_value == '0) && (rsp_popped_priority == '0), "entry fields set without a pop")
   `SPQ_ASSERT_NOW(a_empty_full, rsp_valid && ((rsp_status == ST_EMPTY) || (rsp_status == ST_FULL)), (rsp_status == ST_EMPTY) ? (rsp_occupancy == '0) : (rsp_occupancy == OCC_W'(CAPACITY)), "occupancy disagrees with status")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_popped_value    (rsp_ch.popped_value),
   .rsp_popped_priority (rsp_ch.popped_priority),
   .rsp_occupancy       (rsp_ch.occupancy)
);

FILE: verif/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   // One request beat as the sender presents it.
   typedef struct {
      logic                     op;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } request_type;

   // One response beat as the queue should return it.
   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic [OCC_W-1:0]         occupancy;
   } outcome_type;

   // Shapes of the random traffic: mostly pushes, mostly pops, or an even mix.
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   // Ways in which the response side holds off the queue.
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_type;

   // Allow for the slowest push, which walks past every held entry, plus the
   // longest response stall and the longest sender gap, several times over,
   // before declaring the run hung.
   localparam int STALL_LIMIT  = 600;
   // Cycles allowed after the last response for a stray extra beat to show up.
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 900;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Shadow copy of the queue. Entries are kept in ascending priority order, the
   // lowest priority at slot zero. Only slots below held_count are ever read.
   // ---------------------------------------------------------------------------
   entry_type shadow_store [CAPACITY];
   int        held_count = 0;

   request_type  feed_q [$];
   outcome_type  outcome_fifo [$];

   int        items_planned  = 0;
   int        items_accepted = 0;
   int        mismatch_count = 0;
   int        idle_cycles    = 0;
   logic      req_beat       = 1'b0;

   // Tallies of what the accepted traffic exercised, for the closing summary.
   int        n_pushed = 0;
   int        n_popped = 0;
   int        n_full   = 0;
   int        n_empty  = 0;
   int        peak_held = 0;

   // Sender burst and gap state, and the receiver's stall pattern.
   int           burst_left = 0;
   int           gap_left   = 0;
   rx_mode_type  rx_mode    = RX_OPEN;
   int           rx_mode_left = 0;
   int           rx_hold_left = 0;
   int           rx_cycle     = 0;

   // Applies one operation to the shadow queue and returns the response it
   // should produce. A push slides the new entry down from the tail past every
   // entry whose priority is greater than or equal to its own, which puts it in
   // front of older entries of the same priority.
   function automatic outcome_type queue_outcome(input request_type r);
      outcome_type o;
      int          slot;
      o = '0;
      if (r.op == OP_PUSH) begin
         if (held_count >= CAPACITY) begin
            o.status = ST_FULL;
         end else begin
            slot = held_count;
            while (slot > 0 && $signed(shadow_store[slot-1].prio) >= r.prio) begin
               shadow_store[slot] = shadow_store[slot-1];
               slot--;
            end
            shadow_store[slot].value = r.value;
            shadow_store[slot].prio  = r.prio;
            held_count++;
            o.status = ST_PUSHED;
         end
      end else begin
         if (held_count == 0) begin
            o.status = ST_EMPTY;
         end else begin
            o.value = shadow_store[0].value;
            o.prio  = shadow_store[0].prio;
            for (slot = 1; slot < held_count; slot++) begin
               shadow_store[slot-1] = shadow_store[slot];
            end
            held_count--;
            o.status = ST_POPPED;
         end
      end
      o.occupancy = OCC_W'(held_count);
      return o;
   endfunction

   // Prints one line for a field that differs and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: %s differs, got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic add_item(input logic op, input logic [DATA_W-1:0] value,
                           input logic [DATA_W-1:0] prio);
      request_type r;
      r.op    = op;
      r.value = value;
      r.prio  = prio;
      feed_q.push_back(r);
   endtask

   // Priorities are drawn most often from a narrow band so that ties are common,
   // with the extremes and the full 32-bit range mixed in.
   function automatic logic [DATA_W-1:0] pick_priority();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         return DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
      end else if (sel < 50) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end else if (sel < 80) begin
         return DATA_W'($urandom_range(0, 2000)) - DATA_W'(1000);
      end
      return $urandom;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender. Inputs change on the falling edge. A beat that was taken at the
   // last rising edge frees the channel for the next item; otherwise the current
   // one is held. Items go out in bursts of random length, and between bursts
   // there is either no gap at all or a random one.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : sender
      request_type next_req;
      logic        drive_valid;
      drive_valid = req_bus.valid;
      if (reset) begin
         drive_valid = 1'b0;
      end else if (!req_bus.valid || req_beat) begin
         drive_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (feed_q.size() != 0) begin
            next_req = feed_q.pop_front();
            drive_valid = 1'b1;
            req_bus.op            <= next_req.op;
            req_bus.item_value    <= next_req.value;
            req_bus.item_priority <= next_req.prio;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
      end
      req_bus.valid <= drive_valid;
   end

   // ---------------------------------------------------------------------------
   // Receiver. It switches every so often between always taking beats, taking
   // them on a coin toss, taking one cycle in four, and holding off for long
   // random stretches.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      logic take;
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 120);
         rx_hold_left = 0;
      end else begin
         rx_mode_left--;
      end
      rx_cycle++;
      case (rx_mode)
         RX_OPEN:   take = 1'b1;
         RX_COIN:   take = 1'($urandom_range(0, 1));
         RX_SPARSE: take = (rx_cycle % 4 == 0);
         default: begin
            if (rx_hold_left == 0) begin
               take = 1'b1;
               rx_hold_left = $urandom_range(1, 16);
            end else begin
               take = 1'b0;
               rx_hold_left--;
            end
         end
      endcase
      rsp_bus.ready <= take;
   end

   // ---------------------------------------------------------------------------
   // Monitor and scoreboard, sampled on the rising edge. A response beat is
   // checked against the oldest outstanding outcome before any request taken at
   // the same edge is added, since a response always belongs to an earlier
   // request. The same block keeps the count of cycles without any beat.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      outcome_type want;
      request_type got_req;
      if (reset) begin
         req_beat    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcome_fifo.size() == 0) begin
               report_mismatch("unrequested response status", 32'(rsp_bus.status), '0);
            end else begin
               want = outcome_fifo.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
               if (rsp_bus.popped_value !== want.value)
                  report_mismatch("popped_value", rsp_bus.popped_value, want.value);
               if (rsp_bus.popped_priority !== want.prio)
                  report_mismatch("popped_priority", rsp_bus.popped_priority, want.prio);
               if (rsp_bus.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_bus.occupancy),
                                  32'(want.occupancy));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            got_req.op    = req_bus.op;
            got_req.value = req_bus.item_value;
            got_req.prio  = req_bus.item_priority;
            want = queue_outcome(got_req);
            outcome_fifo.push_back(want);
            items_accepted++;
            case (want.status)
               ST_PUSHED: n_pushed++;
               ST_POPPED: n_popped++;
               ST_EMPTY:  n_empty++;
               default:   n_full++;
            endcase
            if (held_count > peak_held) peak_held = held_count;
         end
         req_beat    <= req_bus.valid && req_bus.ready;
         idle_cycles <= ((req_bus.valid && req_bus.ready) ||
                         (rsp_bus.valid && rsp_bus.ready)) ? 0 : idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------------
   initial begin : run
      traffic_mix_type mix;
      int              mix_left;
      int              pop_share;
      int              n;

      req_bus.valid         = 1'b0;
      req_bus.op            = OP_PUSH;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      rsp_bus.ready         = 1'b0;

      // Directed opening. A pop on the empty queue comes first. Then sixteen
      // pushes fill the queue: the value and priority extremes, all-ones, runs
      // of equal priority (the newest must come out first), ties with the
      // minimum and the maximum, and alternating bit patterns. A seventeenth
      // push must be dropped as full. Six pops with junk in the ignored fields
      // then take entries off the head; the rest drain in the random part.
      add_item(OP_POP,  32'h1234_5678, 32'h9ABC_DEF0);
      add_item(OP_PUSH, 32'h7FFF_FFFF, 32'h0000_0000);
      add_item(OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(OP_PUSH, 32'h0000_0000, 32'h8000_0000);
      add_item(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(OP_PUSH, 32'h0000_0011, 32'd5);
      add_item(OP_PUSH, 32'h0000_0022, 32'd5);
      add_item(OP_PUSH, 32'h0000_0033, 32'd5);
      add_item(OP_PUSH, 32'hAAAA_AAAA, 32'd100);
      add_item(OP_PUSH, 32'h5555_5555, -32'sd100);
      add_item(OP_PUSH, 32'h0000_0001, 32'h8000_0000);
      add_item(OP_PUSH, 32'h0000_0002, 32'h7FFF_FFFF);
      add_item(OP_PUSH, 32'h0000_0003, 32'h0000_0000);
      add_item(OP_PUSH, 32'h0000_0004, 32'd5);
      add_item(OP_PUSH, 32'h0000_0005, 32'hFFFF_FFFF);
      add_item(OP_PUSH, 32'h0000_0006, 32'd7);
      add_item(OP_PUSH, 32'h0000_0007, 32'd2);
      add_item(OP_PUSH, 32'hDEAD_BEEF, 32'd3);
      for (n = 0; n < 6; n++) begin
         add_item(OP_POP, $urandom, $urandom);
      end

      // Random part, in phases that lean towards filling, draining or neither,
      // so the queue keeps passing through empty, full and everything between.
      mix_left = 0;
      mix      = MIX_EVEN;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (mix_left == 0) begin
            mix      = traffic_mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(10, 60);
         end
         mix_left--;
         case (mix)
            MIX_FILL:  pop_share = 15;
            MIX_DRAIN: pop_share = 85;
            default:   pop_share = 50;
         endcase
         if ($urandom_range(0, 99) < pop_share) begin
            add_item(OP_POP, $urandom, $urandom);
         end else begin
            add_item(OP_PUSH, $urandom, pick_priority());
         end
      end
      items_planned = feed_q.size();

      // Reset is held, then released on a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every item has been taken and answered, or the queue hangs.
      while (!(items_accepted == items_planned && outcome_fifo.size() == 0) &&
             idle_cycles < STALL_LIMIT) begin
         @(negedge clock);
      end
      // Give a stray extra response the chance to appear.
      if (idle_cycles < STALL_LIMIT) begin
         repeat (DRAIN_CYCLES) @(negedge clock);
      end

      $display("Run covered %0d requests: %0d pushes, %0d pops, %0d dropped on full,",
               items_accepted, n_pushed, n_popped, n_full);
      $display("%0d pops on empty, peak occupancy %0d of %0d, %0d field errors.",
               n_empty, peak_held, CAPACITY, mismatch_count);
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat moved for %0d cycles, %0d responses outstanding.",
                  STALL_LIMIT, outcome_fifo.size());
         $display("SCOREBOARD MISMATCH");
      end else if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
